// File: design/rbst_pkg.sv
// Shared constants and types for the ray/box slab test.
// No dependencies.
package rbst_pkg;

	localparam int unsigned QW      = 32;            // Q16.16 word
	localparam int unsigned FRAC    = 16;            // fraction bits
	localparam int unsigned AXES    = 3;
	localparam int unsigned DIV_B   = QW + 1 + FRAC; // numerator / quotient bits
	localparam int unsigned TW      = DIV_B + 1;     // signed distance width
	localparam int unsigned NSTG    = DIV_B + 4;     // prep, divide, finish, merge x2
	localparam int unsigned IN_W    = 12 * QW;
	localparam int unsigned OUT_W   = ((2 * QW + 1 + 7) / 8) * 8;

	typedef logic signed [QW-1:0] q_t;
	typedef logic signed [TW-1:0] dist_t;

	typedef struct packed {
		logic neg_a;
		logic neg_b;
		logic zero_dir;
		logic in_slab;
	} div_tag_t;

	typedef struct packed {
		dist_t lo;
		dist_t hi;
		logic  miss;
	} slab_t;

	localparam dist_t T_NEG_INF = {1'b1, {(TW-1){1'b0}}};
	localparam dist_t T_POS_INF = {1'b0, {(TW-1){1'b1}}};
	localparam dist_t T_QMAX    = dist_t'({1'b0, {(QW-1){1'b1}}});
	localparam dist_t T_QMIN    = {{(TW-QW+1){1'b1}}, {(QW-1){1'b0}}};

endpackage

// File: design/rbst_div.sv
// Pipelined restoring divider: two unsigned numerators over one divisor,
// one quotient bit per stage, with a side tag. Depends on rbst_pkg.
module rbst_div (
	input  logic                        clk,
	input  logic [rbst_pkg::DIV_B-1:0]  en,
	input  logic [rbst_pkg::DIV_B-1:0]  num_a,
	input  logic [rbst_pkg::DIV_B-1:0]  num_b,
	input  logic [rbst_pkg::QW-1:0]     den,
	input  rbst_pkg::div_tag_t          tag_in,
	output logic [rbst_pkg::DIV_B-1:0]  quo_a,
	output logic [rbst_pkg::DIV_B-1:0]  quo_b,
	output rbst_pkg::div_tag_t          tag_out
);
	import rbst_pkg::*;

	logic [QW-1:0]    rem_a_q [1:DIV_B];
	logic [QW-1:0]    rem_b_q [1:DIV_B];
	logic [DIV_B-1:0] nq_a_q  [1:DIV_B];
	logic [DIV_B-1:0] nq_b_q  [1:DIV_B];
	logic [QW-1:0]    den_q   [1:DIV_B];
	div_tag_t         tag_q   [1:DIV_B];

	genvar j;
	generate
		for (j = 0; j < DIV_B; j++) begin : g_stage
			logic [QW-1:0]    ra, rb, dd;
			logic [DIV_B-1:0] na, nb;
			div_tag_t         tg;
			logic [QW:0]      sh_a, sh_b;
			logic             ge_a, ge_b;
			logic [QW:0]      df_a, df_b;

			if (j == 0) begin : g_first
				assign ra = '0;
				assign rb = '0;
				assign na = num_a;
				assign nb = num_b;
				assign dd = den;
				assign tg = tag_in;
			end else begin : g_next
				assign ra = rem_a_q[j];
				assign rb = rem_b_q[j];
				assign na = nq_a_q[j];
				assign nb = nq_b_q[j];
				assign dd = den_q[j];
				assign tg = tag_q[j];
			end

			always_comb begin
				sh_a = {ra, na[DIV_B-1]};
				sh_b = {rb, nb[DIV_B-1]};
				ge_a = sh_a >= {1'b0, dd};
				ge_b = sh_b >= {1'b0, dd};
				df_a = sh_a - {1'b0, dd};
				df_b = sh_b - {1'b0, dd};
			end

			always_ff @(posedge clk) begin
				if (en[j]) begin
					rem_a_q[j+1] <= ge_a ? df_a[QW-1:0] : sh_a[QW-1:0];
					rem_b_q[j+1] <= ge_b ? df_b[QW-1:0] : sh_b[QW-1:0];
					nq_a_q[j+1]  <= {na[DIV_B-2:0], ge_a};
					nq_b_q[j+1]  <= {nb[DIV_B-2:0], ge_b};
					den_q[j+1]   <= dd;
					tag_q[j+1]   <= tg;
				end
			end
		end
	endgenerate

	assign quo_a   = nq_a_q[DIV_B];
	assign quo_b   = nq_b_q[DIV_B];
	assign tag_out = tag_q[DIV_B];

endmodule

// File: design/rbst_lane.sv
// One axis of the slab test: plane offsets, two divisions, ordering and
// zero-direction handling. Depends on rbst_pkg and rbst_div.
module rbst_lane (
	input  logic                         clk,
	input  logic [rbst_pkg::DIV_B+1:0]   en,
	input  rbst_pkg::q_t                 origin,
	input  rbst_pkg::q_t                 dir,
	input  rbst_pkg::q_t                 bound_a,
	input  rbst_pkg::q_t                 bound_b,
	output rbst_pkg::slab_t              slab
);
	import rbst_pkg::*;

	logic signed [QW:0] diff_a, diff_b;
	logic [DIV_B-1:0]   num_a_s1, num_b_s1;
	logic [QW-1:0]      den_s1;
	div_tag_t           tag_s1, tag_dv;
	logic [DIV_B-1:0]   quo_a, quo_b;
	dist_t              ta, tb;
	slab_t              slab_q;

	always_comb begin
		diff_a = {bound_a[QW-1], bound_a} - {origin[QW-1], origin};
		diff_b = {bound_b[QW-1], bound_b} - {origin[QW-1], origin};
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			num_a_s1 <= {(diff_a[QW] ? -diff_a : diff_a), {FRAC{1'b0}}};
			num_b_s1 <= {(diff_b[QW] ? -diff_b : diff_b), {FRAC{1'b0}}};
			den_s1   <= dir[QW-1] ? -dir : dir;
			tag_s1.neg_a    <= diff_a[QW] ^ dir[QW-1];
			tag_s1.neg_b    <= diff_b[QW] ^ dir[QW-1];
			tag_s1.zero_dir <= dir == '0;
			tag_s1.in_slab  <= (origin >= bound_a && origin <= bound_b) ||
			                   (origin >= bound_b && origin <= bound_a);
		end
	end

	rbst_div u_div (
		.clk     (clk),
		.en      (en[DIV_B:1]),
		.num_a   (num_a_s1),
		.num_b   (num_b_s1),
		.den     (den_s1),
		.tag_in  (tag_s1),
		.quo_a   (quo_a),
		.quo_b   (quo_b),
		.tag_out (tag_dv)
	);

	always_comb begin
		ta = tag_dv.neg_a ? -dist_t'({1'b0, quo_a}) : dist_t'({1'b0, quo_a});
		tb = tag_dv.neg_b ? -dist_t'({1'b0, quo_b}) : dist_t'({1'b0, quo_b});
	end

	always_ff @(posedge clk) begin
		if (en[DIV_B+1]) begin
			if (tag_dv.zero_dir) begin
				slab_q.lo   <= T_NEG_INF;
				slab_q.hi   <= T_POS_INF;
				slab_q.miss <= !tag_dv.in_slab;
			end else begin
				slab_q.lo   <= (ta < tb) ? ta : tb;
				slab_q.hi   <= (ta < tb) ? tb : ta;
				slab_q.miss <= 1'b0;
			end
		end
	end

	assign slab = slab_q;

endmodule

// File: design/rbst_merge.sv
// Merges the three axis intervals into hit, near and far with saturation.
// Two stages. Depends on rbst_pkg.
module rbst_merge (
	input  logic             clk,
	input  logic [1:0]       en,
	input  rbst_pkg::slab_t  slab_x,
	input  rbst_pkg::slab_t  slab_y,
	input  rbst_pkg::slab_t  slab_z,
	output logic             hit,
	output rbst_pkg::q_t     t_near,
	output rbst_pkg::q_t     t_far
);
	import rbst_pkg::*;

	dist_t nxy, fxy;
	dist_t tn_s1, tf_s1;
	logic  miss_s1;
	dist_t floor0;
	logic  hit_c;
	logic  hit_q;
	q_t    near_q, far_q;

	always_comb begin
		nxy = (slab_x.lo > slab_y.lo) ? slab_x.lo : slab_y.lo;
		fxy = (slab_x.hi < slab_y.hi) ? slab_x.hi : slab_y.hi;
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			tn_s1   <= (nxy > slab_z.lo) ? nxy : slab_z.lo;
			tf_s1   <= (fxy < slab_z.hi) ? fxy : slab_z.hi;
			miss_s1 <= slab_x.miss | slab_y.miss | slab_z.miss;
		end
	end

	always_comb begin
		floor0 = tn_s1[TW-1] ? '0 : tn_s1;
		hit_c  = !miss_s1 && (tf_s1 >= floor0) && (tn_s1 < T_QMAX);
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			hit_q <= hit_c;
			if (!hit_c) begin
				near_q <= '0;
				far_q  <= '0;
			end else begin
				near_q <= (tn_s1 > T_QMAX) ? QW'(T_QMAX) :
				          (tn_s1 < T_QMIN) ? QW'(T_QMIN) : QW'(tn_s1);
				far_q  <= (tf_s1 > T_QMAX) ? QW'(T_QMAX) :
				          (tf_s1 < T_QMIN) ? QW'(T_QMIN) : QW'(tf_s1);
			end
		end
	end

	assign hit    = hit_q;
	assign t_near = near_q;
	assign t_far  = far_q;

endmodule

// File: design/ray_box_slab_test.sv
// Ray versus axis-aligned box slab test, three axis lanes plus merge.
// One transaction per cycle from input to result while m_tready does not stall the pipeline.
// The 49-stage pipelined divider in each lane sets the depth; stalls collapse bubbles.
// Reset (arst_n low) clears all stage valid bits; data registers are not reset.
// Depends on rbst_pkg, rbst_lane, rbst_div, rbst_merge.
module ray_box_slab_test (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// origin_x,y,z, dir_x,y,z, box_min_x,y,z, box_max_x,y,z (32 bits each)
	input  logic [rbst_pkg::IN_W-1:0]     s_tdata,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// hit, t_near, t_far, zero pad
	output logic [rbst_pkg::OUT_W-1:0]    m_tdata
);
	import rbst_pkg::*;

	logic [NSTG:1]   vld_q;
	logic [NSTG+1:1] rdy;
	logic [NSTG:1]   en;
	slab_t           slab [0:AXES-1];
	logic            hit;
	q_t              t_near, t_far;

	always_comb begin
		rdy[NSTG+1] = m_tready;
		for (int k = NSTG; k >= 1; k--)
			rdy[k] = !vld_q[k] || rdy[k+1];
		en = rdy[NSTG:1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[1])
				vld_q[1] <= s_tvalid;
			for (int k = 2; k <= NSTG; k++)
				if (en[k])
					vld_q[k] <= vld_q[k-1];
		end
	end

	genvar a;
	generate
		for (a = 0; a < AXES; a++) begin : g_lane
			rbst_lane u_lane (
				.clk     (clk),
				.en      (en[DIV_B+2:1]),
				.origin  (s_tdata[a*QW +: QW]),
				.dir     (s_tdata[(3+a)*QW +: QW]),
				.bound_a (s_tdata[(6+a)*QW +: QW]),
				.bound_b (s_tdata[(9+a)*QW +: QW]),
				.slab    (slab[a])
			);
		end
	endgenerate

	rbst_merge u_merge (
		.clk    (clk),
		.en     (en[NSTG:NSTG-1]),
		.slab_x (slab[0]),
		.slab_y (slab[1]),
		.slab_z (slab[2]),
		.hit    (hit),
		.t_near (t_near),
		.t_far  (t_far)
	);

	assign s_tready = rdy[1];
	assign m_tvalid = vld_q[NSTG];
	assign m_tdata  = {{(OUT_W-2*QW-1){1'b0}}, t_far, t_near, hit};

`ifndef SYNTHESIS
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[0] |-> m_tdata[2*QW:1] == '0)
		else $error("miss result carries nonzero distances");
	a_hit_order: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[0] |->
			$signed(m_tdata[2*QW:QW+1]) >= $signed(m_tdata[QW:1]))
		else $error("hit with far below near");
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (&vld_q) && !m_tready)
		else $error("input stalled with a bubble in the pipeline");
`endif

endmodule
